[rtl/slle_pkg.sv]
// Shared types and codes for the sequential list engine.
// No dependencies; compile first.
package slle_pkg;

    // Width of cell index fields, enough for the largest supported list
    localparam int IDX_W = 17;

    typedef enum logic [2:0] {
        ACT_INSERT       = 3'd0,
        ACT_DELETE_AT    = 3'd1,
        ACT_FIND         = 3'd2,
        ACT_COUNT        = 3'd3,
        ACT_DEDUP        = 3'd4,
        ACT_DELETE_RANGE = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PASS,
        ST_DEDUP,
        ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_PASS
    } cell_op_t;

    // Broadcast control for the cell row
    typedef struct packed {
        cell_op_t           op;
        logic [IDX_W-1:0]   target;
        logic               keep;
        logic signed [31:0] data;
    } cell_ctrl_t;

endpackage

[rtl/slle_if.sv]
// Valid/ready channel interfaces for commands and answers.
// Depends on nothing; compile after slle_pkg.
interface slle_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic [8:0]         position;
    logic signed [31:0] value;
    logic signed [31:0] upper;

    modport source (output valid, action, position, value, upper, input ready);
    modport sink (input valid, action, position, value, upper, output ready);
endinterface

interface slle_ans_if;
    logic       valid;
    logic       ready;
    logic [8:0] answer;

    modport source (output valid, answer, input ready);
    modport sink (input valid, answer, output ready);
endinterface

[rtl/slle_cell.sv]
// One list cell: holds a single entry and trades it with its neighbors.
// Depends on slle_pkg.
module slle_cell
    import slle_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic               clk,
    input  logic signed [31:0] left_val,
    input  logic signed [31:0] right_val,
    input  cell_ctrl_t         ctrl,
    output logic signed [31:0] val
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [31:0] val_reg;
    logic signed [31:0] val_next;

    // Insert opens a slot, delete closes one, a pass rotates toward cell 0
    always_comb
    begin
        val_next = val_reg;
        unique case (ctrl.op)
            CELL_INSERT:
            begin
                if (MY_IDX == ctrl.target)
                    val_next = ctrl.data;
                else if (MY_IDX > ctrl.target)
                    val_next = left_val;
            end
            CELL_DELETE:
            begin
                if (MY_IDX >= ctrl.target)
                    val_next = right_val;
            end
            CELL_PASS:
            begin
                if (ctrl.keep && MY_IDX == ctrl.target)
                    val_next = ctrl.data;
                else
                    val_next = right_val;
            end
            default: val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

[rtl/sequential_list_engine_core.sv]
// Ordered list of up to CAPACITY signed 32-bit entries held in a row of cells.
// Insert and delete-at-position update the cells in the cycle they are accepted.
// Delete-range rotates the list once through cell 0. Find and count also
// load the answer register and wait while the answer side stalls.
// Deduplicate runs one rotation per distinct value, each rotation followed by
// a turn that moves the checked entry to the back and brings the next
// unchecked entry to cell 0.
// Find and count give one answer transfer; other commands give none.
module sequential_list_engine_core
    import slle_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    slle_cmd_if.sink   cmd,
    slle_ans_if.source rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CW > 9) ? CW : 9;
    localparam int PW = AW + 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    state_t             state_reg, state_next;
    logic [CW-1:0]      len_reg;
    action_t            act_reg;
    logic signed [31:0] key_reg;
    logic signed [31:0] upper_reg;
    logic [CW-1:0]      steps_reg;
    logic [CW-1:0]      step_reg;
    logic [CW-1:0]      done_reg;
    logic [AW-1:0]      ans_reg;
    logic               out_valid_reg;
    logic [8:0]         out_answer_reg;

    logic signed [31:0] cell_val [CAPACITY];
    logic signed [31:0] head;
    cell_ctrl_t         ctrl;
    logic               accept;
    logic               pass_end;
    logic               step_active;
    logic               in_rng;
    logic               keep;
    logic               ins_ok;
    logic               del_ok;
    logic [PW-1:0]      pos_w;
    logic [PW-1:0]      len_w;
    logic               out_free;

    assign head        = cell_val[0];
    assign accept      = cmd.valid && cmd.ready;
    assign cmd.ready   = (state_reg == ST_IDLE);
    assign pass_end    = (step_reg == steps_reg);
    assign step_active = (state_reg == ST_PASS) && !pass_end;
    assign in_rng      = (head >= key_reg) && (head <= upper_reg);
    assign pos_w       = PW'(cmd.position);
    assign len_w       = PW'(len_reg);
    assign ins_ok      = (cmd.position != 9'd0) && (pos_w <= len_w + PW'(1))
                         && (len_reg != CAP_C);
    assign del_ok      = (cmd.position != 9'd0) && (pos_w <= len_w);
    assign out_free    = !out_valid_reg || rsp.ready;

    // Keep decision for the entry leaving cell 0
    always_comb
    begin
        case (act_reg)
            ACT_DELETE_RANGE: keep = !in_rng;
            ACT_DEDUP:        keep = (step_reg == '0) || (head != key_reg);
            default:          keep = 1'b1;
        endcase
    end

    // Cell row control
    always_comb
    begin
        ctrl.op     = CELL_HOLD;
        ctrl.target = '0;
        ctrl.keep   = keep;
        ctrl.data   = head;
        if (step_active)
        begin
            ctrl.op     = CELL_PASS;
            ctrl.target = IDX_W'(len_reg) - IDX_W'(1);
        end
        else if (state_reg == ST_DEDUP && done_reg != '0)
        begin
            // Move the value just checked behind the others
            ctrl.op     = CELL_PASS;
            ctrl.target = IDX_W'(len_reg) - IDX_W'(1);
            ctrl.keep   = 1'b1;
        end
        else if (accept && action_t'(cmd.action) == ACT_INSERT && ins_ok)
        begin
            ctrl.op     = CELL_INSERT;
            ctrl.target = IDX_W'(cmd.position) - IDX_W'(1);
            ctrl.data   = cmd.value;
        end
        else if (accept && action_t'(cmd.action) == ACT_DELETE_AT && del_ok)
        begin
            ctrl.op     = CELL_DELETE;
            ctrl.target = IDX_W'(cmd.position) - IDX_W'(1);
        end
    end

    // Cell row
    for (genvar gi = 0; gi < CAPACITY; gi++)
    begin : g_cell
        logic signed [31:0] left_v;
        logic signed [31:0] right_v;
        if (gi == 0)
        begin : g_first
            assign left_v = cell_val[0];
        end
        else
        begin : g_mid
            assign left_v = cell_val[gi-1];
        end
        if (gi == CAPACITY - 1)
        begin : g_last
            assign right_v = cell_val[gi];
        end
        else
        begin : g_body
            assign right_v = cell_val[gi+1];
        end
        slle_cell #(.INDEX(gi)) u_cell (
            .clk       (clk),
            .left_val  (left_v),
            .right_val (right_v),
            .ctrl      (ctrl),
            .val       (cell_val[gi])
        );
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action_t'(cmd.action))
                        ACT_FIND, ACT_COUNT, ACT_DELETE_RANGE: state_next = ST_PASS;
                        ACT_DEDUP: state_next = ST_DEDUP;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PASS:
            begin
                if (pass_end)
                begin
                    case (act_reg)
                        ACT_FIND, ACT_COUNT: state_next = ST_RESULT;
                        ACT_DEDUP:           state_next = ST_DEDUP;
                        default:             state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DEDUP:
            begin
                state_next = (done_reg == len_reg) ? ST_IDLE : ST_PASS;
            end
            ST_RESULT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctrl.op == CELL_INSERT)
                len_reg <= len_reg + CW'(1);
            else if (ctrl.op == CELL_DELETE)
                len_reg <= len_reg - CW'(1);
            else if (ctrl.op == CELL_PASS && !ctrl.keep)
                len_reg <= len_reg - CW'(1);
            if (state_reg == ST_RESULT && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Command, pass and answer registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= action_t'(cmd.action);
            key_reg   <= cmd.value;
            upper_reg <= cmd.upper;
            steps_reg <= len_reg;
            step_reg  <= '0;
            ans_reg   <= '0;
            done_reg  <= '0;
        end
        else if (state_reg == ST_DEDUP && done_reg != len_reg)
        begin
            // Next unchecked value lands in cell 0 this cycle
            key_reg   <= (done_reg == '0) ? head : cell_val[1];
            steps_reg <= len_reg;
            step_reg  <= '0;
        end
        else if (step_active)
        begin
            step_reg <= step_reg + CW'(1);
            if (act_reg == ACT_FIND && ans_reg == '0 && head == key_reg)
                ans_reg <= AW'(step_reg) + AW'(1);
            else if (act_reg == ACT_COUNT && in_rng)
                ans_reg <= ans_reg + AW'(1);
        end
        else if (state_reg == ST_PASS && act_reg == ACT_DEDUP)
        begin
            done_reg <= done_reg + CW'(1);
        end
        if (state_reg == ST_RESULT && out_free)
            out_answer_reg <= ans_reg[8:0];
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.answer = out_answer_reg;

endmodule
